// ===== sv/gdp_pkg.sv =====
// ----------------------------------------------------------------------------
// gdp_pkg
// Shared types, widths and helpers of the descending path counter.
// ----------------------------------------------------------------------------
package gdp_pkg;

   localparam int CELL_W  = 16;
   localparam int SIDE_W  = 9;
   localparam int COUNT_W = 64;
   localparam int DEG_W   = 3;
   localparam int CLAMP_W = 11;

   typedef logic [1:0] dir_type;
   localparam dir_type DIR_UP    = 2'd0;
   localparam dir_type DIR_RIGHT = 2'd1;
   localparam dir_type DIR_DOWN  = 2'd2;
   localparam dir_type DIR_LEFT  = 2'd3;

   typedef enum logic [11:0] {
      ST_LOAD = 12'b000000000001,
      ST_ICEN = 12'b000000000010,
      ST_IHGT = 12'b000000000100,
      ST_INB  = 12'b000000001000,
      ST_IWR  = 12'b000000010000,
      ST_KPOP = 12'b000000100000,
      ST_KCEN = 12'b000001000000,
      ST_KHGT = 12'b000010000000,
      ST_KNRD = 12'b000100000000,
      ST_KNUP = 12'b001000000000,
      ST_KEND = 12'b010000000000,
      ST_DONE = 12'b100000000000
   } state_type;

   function automatic logic [COUNT_W:0] sat_add(input logic [COUNT_W-1:0] a,
                                                input logic [COUNT_W-1:0] b);
      logic [COUNT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s[COUNT_W]) begin
         s = {1'b1, {COUNT_W{1'b1}}};
      end
      return s;
   endfunction

endpackage

// ===== sv/gdp_if.sv =====
// ----------------------------------------------------------------------------
// gdp channel interfaces
// Valid/ready channels for cells, results and the side length register.
// ----------------------------------------------------------------------------
interface gdp_req_if;
   import gdp_pkg::*;
   logic              valid;
   logic              ready;
   logic [CELL_W-1:0] cell_value;
   modport source (output valid, output cell_value, input ready);
   modport sink (input valid, input cell_value, output ready);
endinterface

interface gdp_rsp_if;
   import gdp_pkg::*;
   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] path_count;
   logic               overflow;
   modport source (output valid, output path_count, output overflow, input ready);
   modport sink (input valid, input path_count, input overflow, output ready);
endinterface

interface gdp_csr_if;
   import gdp_pkg::*;
   logic              valid;
   logic              ready;
   logic [SIDE_W-1:0] side_length;
   modport source (output valid, output side_length, input ready);
   modport sink (input valid, input side_length, output ready);
endinterface

// ===== sv/gdp_ram.sv =====
// ----------------------------------------------------------------------------
// gdp_ram
// Simple dual port memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module gdp_ram #(
   parameter int ADDR_W = 16,
   parameter int DATA_W = 16
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [DATA_W-1:0] wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [DATA_W-1:0] rdata
);
   logic [DATA_W-1:0] mem [2**ADDR_W];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

// ===== sv/grid_descending_path_counter_core.sv =====
// ----------------------------------------------------------------------------
// grid_descending_path_counter_core
// Counts maximal strictly descending paths over a square grid of heights.
// ----------------------------------------------------------------------------
// csr_if writes the side length n and restarts the load. req_if takes one
// cell word per cycle in row-major order. After the last of n*n cells the
// block stops taking cells and computes:
//   in-degree pass: ICEN, IHGT, INB per direction, IWR; reads the cell and
//   its four neighbours from the cell memory, pushes sources on the queue memory
//   topological walk: KPOP, KCEN, KHGT, KNRD per direction, KNUP per
//   neighbour inside the grid, KEND; reads through the single cell memory
//   read port; a final KPOP finds the queue empty
// No clearing pass is needed, every entry is rewritten by the in-degree pass.
// One rsp_if word (path_count, overflow) is produced per grid. It sits in an
// output register; the next grid loads while it waits, and a finished count
// holds the block until the previous word is taken.
// Reset: side length 1, load position 0, no result pending.
// ----------------------------------------------------------------------------
module grid_descending_path_counter_core #(
   parameter int SIDE_MAX    = 256,
   parameter int HEIGHT_BITS = 16
) (
   input  logic      clock,
   input  logic      reset,
   gdp_req_if.sink   req_if,
   gdp_rsp_if.source rsp_if,
   gdp_csr_if.sink   csr_if
);
   import gdp_pkg::*;

   localparam int CW = (SIDE_MAX > 1) ? $clog2(SIDE_MAX) : 1;
   localparam int SW = $clog2(SIDE_MAX + 1);
   localparam int AW = 2 * CW;
   localparam int QW = AW + 1;
   localparam int HW = HEIGHT_BITS;
   localparam int WW = HW + DEG_W + COUNT_W;

   state_type          state_ff, state_in;
   logic [SIDE_W-1:0]  side_ff, side_in;
   logic [CW-1:0]      pr_ff, pr_in, pc_ff, pc_in;
   dir_type            dir_ff, dir_in;
   logic               nbok_ff, nbok_in;
   logic [HW-1:0]      hp_ff, hp_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   logic [DEG_W-1:0]   deg_ff, deg_in;
   logic               sink_ff, sink_in;
   logic [QW-1:0]      head_ff, head_in, tail_ff, tail_in;
   logic [COUNT_W-1:0] total_ff, total_in;
   logic               ovf_ff, ovf_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic               rsp_ovf_ff, rsp_ovf_in;

   logic               cwe, qwe;
   logic [AW-1:0]      cwaddr, craddr, qwaddr, qraddr;
   logic [WW-1:0]      cwdata, crdata;
   logic [AW-1:0]      qwdata, qrdata;

   logic [CLAMP_W-1:0] side_ext, n_ext;
   logic [SW-1:0]      n_side, n_last;
   logic               r_first, r_last, c_first, c_last, grid_last;
   logic [CW-1:0]      pr_next, pc_next;
   dir_type            dir_sel;
   logic               nb_ok;
   logic [AW-1:0]      nb_addr;
   logic [31:0]        val32;
   logic [HW-1:0]      rd_h;
   logic [DEG_W-1:0]   rd_deg;
   logic [COUNT_W-1:0] rd_cnt;
   logic [COUNT_W-1:0] sa_a;
   logic [COUNT_W:0]   sa;

   gdp_ram #(.ADDR_W(AW), .DATA_W(WW)) u_cell_ram (
      .clock(clock), .we(cwe), .waddr(cwaddr), .wdata(cwdata),
      .raddr(craddr), .rdata(crdata)
   );

   gdp_ram #(.ADDR_W(AW), .DATA_W(AW)) u_queue_ram (
      .clock(clock), .we(qwe), .waddr(qwaddr), .wdata(qwdata),
      .raddr(qraddr), .rdata(qrdata)
   );

   // active side length, clamped to 1..SIDE_MAX
   assign side_ext = CLAMP_W'(side_ff);
   assign n_ext    = (side_ext == '0) ? CLAMP_W'(1) :
                     (side_ext > CLAMP_W'(SIDE_MAX)) ? CLAMP_W'(SIDE_MAX) : side_ext;
   assign n_side   = n_ext[SW-1:0];
   assign n_last   = n_side - SW'(1);

   assign r_first   = (pr_ff == '0);
   assign c_first   = (pc_ff == '0);
   assign r_last    = (SW'(pr_ff) == n_last);
   assign c_last    = (SW'(pc_ff) == n_last);
   assign grid_last = r_last && c_last;
   assign pc_next   = c_last ? '0 : CW'(pc_ff + 1'b1);
   assign pr_next   = c_last ? (r_last ? '0 : CW'(pr_ff + 1'b1)) : pr_ff;

   assign dir_sel = (state_ff == ST_INB) ? dir_type'(dir_ff + 1'b1) : dir_ff;

   always_comb begin
      nb_ok   = 1'b0;
      nb_addr = {pr_ff, pc_ff};
      case (dir_sel)
         DIR_UP: begin
            nb_ok   = !r_first;
            nb_addr = {CW'(pr_ff - 1'b1), pc_ff};
         end
         DIR_RIGHT: begin
            nb_ok   = !c_last;
            nb_addr = {pr_ff, CW'(pc_ff + 1'b1)};
         end
         DIR_DOWN: begin
            nb_ok   = !r_last;
            nb_addr = {CW'(pr_ff + 1'b1), pc_ff};
         end
         default: begin
            nb_ok   = !c_first;
            nb_addr = {pr_ff, CW'(pc_ff - 1'b1)};
         end
      endcase
   end

   assign val32  = 32'(req_if.cell_value);
   assign rd_h   = crdata[WW-1 -: HW];
   assign rd_deg = crdata[COUNT_W +: DEG_W];
   assign rd_cnt = crdata[COUNT_W-1:0];
   assign sa_a   = (state_ff == ST_KEND) ? total_ff : rd_cnt;
   assign sa     = sat_add(sa_a, cnt_ff);

   assign req_if.ready      = (state_ff == ST_LOAD);
   assign csr_if.ready      = 1'b1;
   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.path_count = rsp_count_ff;
   assign rsp_if.overflow   = rsp_ovf_ff;

   always_comb begin
      state_in     = state_ff;
      side_in      = side_ff;
      pr_in        = pr_ff;
      pc_in        = pc_ff;
      dir_in       = dir_ff;
      nbok_in      = nbok_ff;
      hp_in        = hp_ff;
      cnt_in       = cnt_ff;
      deg_in       = deg_ff;
      sink_in      = sink_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      total_in     = total_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_count_in = rsp_count_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      cwe          = 1'b0;
      cwaddr       = {pr_ff, pc_ff};
      cwdata       = '0;
      craddr       = {pr_ff, pc_ff};
      qwe          = 1'b0;
      qwaddr       = tail_ff[AW-1:0];
      qwdata       = {pr_ff, pc_ff};
      qraddr       = head_ff[AW-1:0];

      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (csr_if.valid) begin
         side_in = csr_if.side_length;
         pr_in   = '0;
         pc_in   = '0;
      end

      unique case (state_ff)
         ST_LOAD: begin
            if (req_if.valid) begin
               cwe    = 1'b1;
               cwdata = {val32[HW-1:0], {DEG_W{1'b0}}, {COUNT_W{1'b0}}};
               pr_in  = pr_next;
               pc_in  = pc_next;
               if (grid_last) begin
                  state_in = ST_ICEN;
                  head_in  = '0;
                  tail_in  = '0;
                  total_in = '0;
                  ovf_in   = 1'b0;
               end
            end
         end
         ST_ICEN: begin
            dir_in   = DIR_UP;
            state_in = ST_IHGT;
         end
         ST_IHGT: begin
            hp_in    = rd_h;
            deg_in   = '0;
            craddr   = nb_addr;
            nbok_in  = nb_ok;
            state_in = ST_INB;
         end
         ST_INB: begin
            if (nbok_ff && hp_ff != '0 && hp_ff < rd_h) begin
               deg_in = DEG_W'(deg_ff + 1'b1);
            end
            craddr  = nb_addr;
            nbok_in = nb_ok;
            dir_in  = dir_type'(dir_ff + 1'b1);
            if (dir_ff == DIR_LEFT) begin
               state_in = ST_IWR;
            end
         end
         ST_IWR: begin
            cwe    = 1'b1;
            cwdata = {hp_ff, deg_ff, (deg_ff == '0) ? COUNT_W'(1) : {COUNT_W{1'b0}}};
            if (deg_ff == '0) begin
               qwe     = 1'b1;
               tail_in = QW'(tail_ff + 1'b1);
            end
            pr_in    = pr_next;
            pc_in    = pc_next;
            state_in = grid_last ? ST_KPOP : ST_ICEN;
         end
         ST_KPOP: begin
            if (head_ff == tail_ff) begin
               state_in = ST_DONE;
            end else begin
               head_in  = QW'(head_ff + 1'b1);
               state_in = ST_KCEN;
            end
         end
         ST_KCEN: begin
            craddr   = qrdata;
            pr_in    = qrdata[AW-1:CW];
            pc_in    = qrdata[CW-1:0];
            state_in = ST_KHGT;
         end
         ST_KHGT: begin
            hp_in    = rd_h;
            cnt_in   = rd_cnt;
            sink_in  = 1'b1;
            dir_in   = DIR_UP;
            state_in = ST_KNRD;
         end
         ST_KNRD: begin
            craddr = nb_addr;
            if (nb_ok) begin
               state_in = ST_KNUP;
            end else begin
               dir_in = dir_type'(dir_ff + 1'b1);
               if (dir_ff == DIR_LEFT) begin
                  state_in = ST_KEND;
               end
            end
         end
         ST_KNUP: begin
            if (rd_h != '0 && rd_h < hp_ff) begin
               sink_in = 1'b0;
               ovf_in  = ovf_ff | sa[COUNT_W];
               cwe     = 1'b1;
               cwaddr  = nb_addr;
               cwdata  = {rd_h, (rd_deg != '0) ? DEG_W'(rd_deg - 1'b1) : rd_deg,
                          sa[COUNT_W-1:0]};
               if (rd_deg == DEG_W'(1)) begin
                  qwe     = 1'b1;
                  qwdata  = nb_addr;
                  tail_in = QW'(tail_ff + 1'b1);
               end
            end
            dir_in   = dir_type'(dir_ff + 1'b1);
            state_in = (dir_ff == DIR_LEFT) ? ST_KEND : ST_KNRD;
         end
         ST_KEND: begin
            if (sink_ff) begin
               total_in = sa[COUNT_W-1:0];
               ovf_in   = ovf_ff | sa[COUNT_W];
            end
            state_in = ST_KPOP;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = total_ff;
               rsp_ovf_in   = ovf_ff;
               pr_in        = '0;
               pc_in        = '0;
               state_in     = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         side_ff      <= SIDE_W'(1);
         pr_ff        <= '0;
         pc_ff        <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         total_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         side_ff      <= side_in;
         pr_ff        <= pr_in;
         pc_ff        <= pc_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         total_ff     <= total_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dir_ff       <= dir_in;
      nbok_ff      <= nbok_in;
      hp_ff        <= hp_in;
      cnt_ff       <= cnt_in;
      deg_ff       <= deg_in;
      sink_ff      <= sink_in;
      rsp_count_ff <= rsp_count_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end
endmodule
